// ----- sv/lcg_pkg.sv -----
`timescale 1ns / 1ps

package lcg_pkg;

  // default grid size
  localparam int LCG_GRID_ROWS = 32;
  localparam int LCG_GRID_COLS = 32;

  // command codes
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [4:0] row_index;
    logic [4:0] col_index;
    logic       cell_in;
  } lcg_in_t;

  typedef struct packed {
    logic cell_out;
  } lcg_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_ADV_FIRST,
    ST_ADV_LAST,
    ST_ADV_ROW,
    ST_FINISH
  } state_e;

endpackage

// ----- sv/lcg_stream_if.sv -----
`timescale 1ns / 1ps

interface lcg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/lcg_ram.sv -----
`timescale 1ns / 1ps

module lcg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/lcg_row_unit.sv -----
`timescale 1ns / 1ps

module lcg_row_unit #(
  parameter int GRID_COLS = 32
) (
  input  logic [GRID_COLS-1:0] up_i,
  input  logic [GRID_COLS-1:0] cur_i,
  input  logic [GRID_COLS-1:0] down_i,
  output logic [GRID_COLS-1:0] next_o
);

  // one neighbour counter and rule per column, all columns in parallel
  for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
    localparam int L = (c + GRID_COLS - 1) % GRID_COLS;
    localparam int R = (c + 1) % GRID_COLS;
    logic [3:0] count;

    assign count = 4'(up_i[L]) + 4'(up_i[c]) + 4'(up_i[R])
                 + 4'(cur_i[L]) + 4'(cur_i[R])
                 + 4'(down_i[L]) + 4'(down_i[c]) + 4'(down_i[R]);

    // birth on three, survival on two or three
    assign next_o[c] = (count == 4'd3) || (cur_i[c] && (count == 4'd2));
  end

endmodule

// ----- sv/life_toroidal_generation_top.sv -----
`timescale 1ns / 1ps

// game of life (b3/s23) on a torus of GRID_ROWS x GRID_COLS cells
// in_i carries one command per beat: write cell, read cell or advance one
// generation; out_o returns one beat per command with the addressed cell
// (0 for advance, unknown commands and addresses outside the grid)
// rows live in one ram, one word per row; a generation runs one row per
// cycle through a single row update unit that handles all columns at once
// flow from acceptance to result: a write or read in the grid reads its row from
//   the ram, then writes the changed bit back or picks the read bit, then finishes;
//   an unknown command or an address outside the grid goes straight to finish;
//   an advance reads the two wrap rows, row 0 and the last row, then does
//   one ram read and write per row, then finishes
// one command is in work at a time; in_i.ready is high only while idle, so no
// new command is taken until the last result has gone into the output register
// after reset a clearing pass writes every row dead, with in_i.ready low
// the result sits in an output register; when out_o stalls the block holds
// the next finished result until the register frees up
module life_toroidal_generation_top
  import lcg_pkg::*;
#(
  parameter int GRID_ROWS = LCG_GRID_ROWS,
  parameter int GRID_COLS = LCG_GRID_COLS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcg_stream_if.sink   in_i,
  lcg_stream_if.source out_o
);

  localparam int RowW = $clog2(GRID_ROWS);
  localparam int ColW = $clog2(GRID_COLS);

  state_e state_q, state_d;

  // row counter, shared by the clearing pass and the advance sweep
  logic [RowW-1:0] cnt_q, cnt_d;
  logic            cnt_last;

  // latched command
  logic [1:0]      cmd_q, cmd_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            cell_q, cell_d;
  logic            value_q, value_d;

  // wrap rows and the sliding window of old rows
  logic [GRID_COLS-1:0] first_q, first_d;
  logic [GRID_COLS-1:0] prior_q, prior_d;
  logic [GRID_COLS-1:0] cur_q, cur_d;
  logic [GRID_COLS-1:0] down;
  logic [GRID_COLS-1:0] next_row;

  // output register
  logic out_valid_q, out_valid_d;
  logic cell_out_q, cell_out_d;

  // ram port
  logic                 ram_we;
  logic [RowW-1:0]      ram_waddr;
  logic [GRID_COLS-1:0] ram_wdata;
  logic                 ram_re;
  logic [RowW-1:0]      ram_raddr;
  logic [GRID_COLS-1:0] ram_rdata;

  logic in_fire;
  logic in_grid;
  logic out_free;
  logic next_readable;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_grid    = (32'(in_i.payload.row_index) < 32'(GRID_ROWS))
                   && (32'(in_i.payload.col_index) < 32'(GRID_COLS));
  assign out_free   = !out_valid_q || out_o.ready;
  assign cnt_last   = (cnt_q == RowW'(GRID_ROWS - 1));

  // row cnt+2 is prefetched while row cnt is written
  assign next_readable = (32'(cnt_q) + 32'd2) < 32'(GRID_ROWS);

  // the last row wraps to the saved old row 0
  assign down = cnt_last ? first_q : ram_rdata;

  lcg_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lcg_row_unit #(
    .GRID_COLS (GRID_COLS)
  ) u_row (
    .up_i   (prior_q),
    .cur_i  (cur_q),
    .down_i (down),
    .next_o (next_row)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.payload.command) inside
            CMD_WRITE, CMD_READ: state_d = in_grid ? ST_ACCESS : ST_FINISH;
            CMD_ADVANCE:         state_d = ST_ADV_FIRST;
            default:             state_d = ST_FINISH;
          endcase
        end
      end
      ST_ACCESS:    state_d = ST_FINISH;
      ST_ADV_FIRST: state_d = ST_ADV_LAST;
      ST_ADV_LAST:  state_d = ST_ADV_ROW;
      ST_ADV_ROW: begin
        if (cnt_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    cell_d      = cell_q;
    value_d     = value_q;
    first_d     = first_q;
    prior_d     = prior_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_o.ready;
    cell_out_d  = cell_out_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = cnt_q;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = cnt_last ? '0 : cnt_q + RowW'(1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d   = in_i.payload.command;
          row_d   = RowW'(in_i.payload.row_index);
          col_d   = ColW'(in_i.payload.col_index);
          cell_d  = in_i.payload.cell_in;
          value_d = 1'b0;
          ram_re  = 1'b1;
          ram_raddr = (in_i.payload.command == CMD_ADVANCE) ? '0
                                                            : RowW'(in_i.payload.row_index);
        end
      end
      ST_ACCESS: begin
        if (cmd_q == CMD_WRITE) begin
          // read-modify-write of one bit in the row
          ram_we           = 1'b1;
          ram_waddr        = row_q;
          ram_wdata        = ram_rdata;
          ram_wdata[col_q] = cell_q;
          value_d          = cell_q;
        end else begin
          value_d = ram_rdata[col_q];
        end
      end
      ST_ADV_FIRST: begin
        first_d   = ram_rdata;
        cur_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = RowW'(GRID_ROWS - 1);
      end
      ST_ADV_LAST: begin
        prior_d   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = RowW'(1);
        cnt_d     = '0;
      end
      ST_ADV_ROW: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = next_row;
        prior_d   = cur_q;
        cur_d     = down;
        ram_re    = next_readable;
        ram_raddr = cnt_q + RowW'(2);
        cnt_d     = cnt_last ? '0 : cnt_q + RowW'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          cell_out_d  = value_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    row_q      <= row_d;
    col_q      <= col_d;
    cell_q     <= cell_d;
    value_q    <= value_d;
    first_q    <= first_d;
    prior_q    <= prior_d;
    cur_q      <= cur_d;
    cell_out_q <= cell_out_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.payload.cell_out = cell_out_q;

`ifndef SYNTHESIS
  // one command in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while a command is in work");

  // the clearing pass writes dead rows only
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> ram_we && (ram_wdata == '0))
    else $error("clearing pass wrote a live cell");

  // a result beat only comes out of the finish step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result raised outside the finish step");

  // an advance always reaches finish through the full row sweep
  a_adv_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADV_ROW && state_d == ST_FINISH |-> cnt_last)
    else $error("advance ended before the last row");
`endif

endmodule

// ----- tb/sv/life_grid_checker.sv -----
`timescale 1ns / 1ps

module life_grid_checker
  import lcg_pkg::*;
#(
  parameter int GRID_ROWS = LCG_GRID_ROWS,
  parameter int GRID_COLS = LCG_GRID_COLS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  lcg_in_t     cmd_beat_i,
  input  logic        cell_valid_i,
  input  logic        cell_ready_i,
  input  lcg_out_t    cell_beat_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct {
    lcg_in_t cmd;
    logic    want;
  } cell_due_t;

  logic [GRID_COLS-1:0] cell_grid [GRID_ROWS];
  cell_due_t            cells_due [$];
  int unsigned          errors;

  // one generation of b3/s23, every neighbour taken from the old grid, wrapped
  function automatic void evolve_grid();
    logic [GRID_COLS-1:0] old_grid [GRID_ROWS];
    int unsigned          live;
    int                   rr;
    int                   cc;
    old_grid = cell_grid;
    for (int r = 0; r < GRID_ROWS; r++) begin
      for (int c = 0; c < GRID_COLS; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              rr = (r + dr + GRID_ROWS) % GRID_ROWS;
              cc = (c + dc + GRID_COLS) % GRID_COLS;
              live += old_grid[rr][cc];
            end
          end
        end
        cell_grid[r][c] = (live == 3) || (old_grid[r][c] && live == 2);
      end
    end
  endfunction

  function automatic logic apply_command(lcg_in_t cmd);
    logic on_grid;
    on_grid = (int'(cmd.row_index) < GRID_ROWS) && (int'(cmd.col_index) < GRID_COLS);
    case (cmd.command)
      CMD_WRITE: begin
        if (!on_grid) return 1'b0;
        cell_grid[cmd.row_index][cmd.col_index] = cmd.cell_in;
        return cmd.cell_in;
      end
      CMD_ADVANCE: begin
        evolve_grid();
        return 1'b0;
      end
      CMD_READ: begin
        if (!on_grid) return 1'b0;
        return cell_grid[cmd.row_index][cmd.col_index];
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    cell_due_t due;
    cell_due_t fresh;
    if (!rst_ni) begin
      for (int r = 0; r < GRID_ROWS; r++) cell_grid[r] = '0;
      cells_due.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cmd_valid_i && cmd_ready_i) begin
        fresh.cmd  = cmd_beat_i;
        fresh.want = apply_command(cmd_beat_i);
        cells_due.push_back(fresh);
      end
      if (cell_valid_i && cell_ready_i) begin
        if (cells_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat cell_out=%0b", cell_beat_i.cell_out);
        end else begin
          due = cells_due.pop_front();
          if (cell_beat_i.cell_out !== due.want) begin
            errors++;
            if (errors <= 10)
              $display("cell_out mismatch cmd=%0d row=%0d col=%0d cell_in=%0b: expected %0b got %0b",
                       due.cmd.command, due.cmd.row_index, due.cmd.col_index,
                       due.cmd.cell_in, due.want, cell_beat_i.cell_out);
          end
        end
      end
      fail_count_o <= errors;
      pending_o <= cells_due.size();
    end
  end

endmodule

// ----- tb/sv/life_toroidal_generation_top_tb.sv -----
`timescale 1ns / 1ps

module life_toroidal_generation_top_tb;
  import lcg_pkg::*;

  localparam int GRID_ROWS   = LCG_GRID_ROWS;
  localparam int GRID_COLS   = LCG_GRID_COLS;
  // quiet cycles allowed: covers the long receiver hold-off, an advance and the clearing pass
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int CMD_TARGET  = 1120;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // percent of cycles each side sits idle, changed per phase by the stimulus
  int unsigned tx_gap_pct = 12;
  int unsigned rx_gap_pct = 54;
  // request for one long receiver hold-off, served once by the receiver process
  logic        hold_req;
  int unsigned cmds_sent;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  lcg_stream_if #(.payload_t(lcg_in_t))  cmd_ch ();
  lcg_stream_if #(.payload_t(lcg_out_t)) cell_ch ();

  always #5 clk_i = ~clk_i;

  life_toroidal_generation_top #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .out_o (cell_ch)
  );

  // prediction and comparison live in the checker, this module only drives and judges
  life_grid_checker #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_ch.valid),
    .cmd_ready_i (cmd_ch.ready),
    .cmd_beat_i  (cmd_ch.payload),
    .cell_valid_i(cell_ch.valid),
    .cell_ready_i(cell_ch.ready),
    .cell_beat_i (cell_ch.payload),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // offer one command beat, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_command(logic [1:0] cmd, logic [4:0] row, logic [4:0] col,
                              logic cell_val);
    lcg_in_t beat;
    beat.command   = cmd;
    beat.row_index = row;
    beat.col_index = col;
    beat.cell_in   = cell_val;
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= beat;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    cmds_sent++;
  endtask

  // seed a small window (addresses wrap at 5 bits, so windows straddle the torus
  // edges), let it evolve a few generations, then read around it
  task automatic plant_and_evolve();
    logic [4:0] base_row;
    logic [4:0] base_col;
    base_row = 5'($urandom_range(0, 31));
    base_col = 5'($urandom_range(0, 31));
    repeat ($urandom_range(4, 12))
      send_command(CMD_WRITE, base_row + 5'($urandom_range(0, 4)),
                   base_col + 5'($urandom_range(0, 4)), $urandom_range(0, 3) != 0);
    repeat ($urandom_range(1, 4))
      send_command(CMD_ADVANCE, 5'($urandom), 5'($urandom), 1'($urandom));
    repeat ($urandom_range(3, 10))
      send_command(CMD_READ, base_row + 5'($urandom_range(0, 6)) - 5'd1,
                   base_col + 5'($urandom_range(0, 6)) - 5'd1, 1'($urandom));
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin : rx_drive
    int unsigned hold_left;
    logic        hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    cell_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        cell_ch.ready <= 1'b0;
      end else begin
        cell_ch.ready <= rst_ni && ($urandom_range(0, 99) >= rx_gap_pct);
      end
    end
  end

  // watchdog: too long without any beat on either channel ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_ch.valid && cmd_ch.ready) || (cell_ch.valid && cell_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cmds_sent = 0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    hold_req       <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fresh grid reads dead, cell_in ignored on read
    send_command(CMD_READ, 5'd0, 5'd0, 1'b1);
    // opposite corners, all address bits high and low
    send_command(CMD_WRITE, 5'd0, 5'd0, 1'b1);
    send_command(CMD_WRITE, 5'd31, 5'd31, 1'b1);
    send_command(CMD_READ, 5'd31, 5'd31, 1'b0);
    send_command(CMD_WRITE, 5'd0, 5'd0, 1'b0);
    send_command(CMD_READ, 5'd0, 5'd0, 1'b1);
    // unknown command leaves the grid alone and returns dead
    send_command(2'd3, 5'd31, 5'd31, 1'b1);
    // blinker across the column wrap on row 15
    send_command(CMD_WRITE, 5'd15, 5'd31, 1'b1);
    send_command(CMD_WRITE, 5'd15, 5'd0, 1'b1);
    send_command(CMD_WRITE, 5'd15, 5'd1, 1'b1);
    // blinker across the row wrap on column 16
    send_command(CMD_WRITE, 5'd31, 5'd16, 1'b1);
    send_command(CMD_WRITE, 5'd0, 5'd16, 1'b1);
    send_command(CMD_WRITE, 5'd1, 5'd16, 1'b1);
    // advance ignores address and cell_in; lone corner cell dies
    send_command(CMD_ADVANCE, 5'd31, 5'd31, 1'b1);
    send_command(CMD_READ, 5'd14, 5'd0, 1'b0);
    send_command(CMD_READ, 5'd16, 5'd0, 1'b0);
    send_command(CMD_READ, 5'd0, 5'd15, 1'b0);
    send_command(CMD_READ, 5'd31, 5'd16, 1'b0);
    send_command(CMD_READ, 5'd31, 5'd31, 1'b0);
    send_command(CMD_ADVANCE, 5'd0, 5'd0, 1'b0);
    send_command(CMD_READ, 5'd15, 5'd31, 1'b0);
    send_command(CMD_READ, 5'd0, 5'd17, 1'b0);

    // random: mostly plant-and-evolve sequences, some single noise commands
    while (cmds_sent < CMD_TARGET) begin
      if (cmds_sent >= CMD_TARGET * 2 / 3) begin
        if (tx_gap_pct != 0) hold_req <= 1'b1;
        tx_gap_pct = 0;
        rx_gap_pct = 0;
      end else if (cmds_sent >= CMD_TARGET / 3) begin
        tx_gap_pct = 54;
        rx_gap_pct = 12;
      end
      if ($urandom_range(0, 3) != 0) begin
        plant_and_evolve();
      end else begin
        send_command(2'($urandom), 5'($urandom), 5'($urandom), 1'($urandom));
      end
    end
    cmd_ch.valid <= 1'b0;

    // drain, then give a stray late beat time to show up
    // wait for the clock first so the last accepted beat is counted as pending
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (GRID_ROWS + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lcg_pkg.sv
sv/lcg_stream_if.sv
sv/lcg_ram.sv
sv/lcg_row_unit.sv
sv/life_toroidal_generation_top.sv
tb/sv/life_grid_checker.sv
tb/sv/life_toroidal_generation_top_tb.sv
